>>> src/arithmetic_expression_lexer_assert.svh
// Assertion macros used by the lexer checker.
`ifndef ARITHMETIC_EXPRESSION_LEXER_ASSERT_SVH
`define ARITHMETIC_EXPRESSION_LEXER_ASSERT_SVH

// Check a same-cycle implication, off while reset is held
`define AEL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lexer assertion failed");

// Check an implication in the next cycle, off while reset is held
`define AEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lexer assertion failed");

`endif

>>> src/ael_pkg.sv
// Types, constants and helper functions of the arithmetic expression lexer.
`timescale 1ns / 1ps
`default_nettype none
package ael_pkg;

	// Number format and fraction digit limit
	localparam int INTEGER_BITS        = 32;
	localparam int FRACTION_BITS       = 16;
	localparam int MAX_FRACTION_DIGITS = 5;

	// Derived widths
	localparam int MANT_W  = $clog2(10 ** MAX_FRACTION_DIGITS);
	localparam int CNT_W   = $clog2(MAX_FRACTION_DIGITS + 1);
	localparam int QUO_W   = FRACTION_BITS + 1;
	localparam int REM_W   = MANT_W + FRACTION_BITS + 1;
	localparam int SUM_W   = INTEGER_BITS + FRACTION_BITS + 1;
	localparam int VALUE_W = 48;

	// Queue depths (powers of two)
	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Token kinds
	localparam logic [2:0] KIND_NUM = 3'd0;
	localparam logic [2:0] KIND_OP  = 3'd1;
	localparam logic [2:0] KIND_BR  = 3'd2;
	localparam logic [2:0] KIND_ERR = 3'd3;
	localparam logic [2:0] KIND_END = 3'd4;

	// Error codes
	localparam logic [1:0] ERR_UNKNOWN      = 2'd0;
	localparam logic [1:0] ERR_UPPER_V      = 2'd1;
	localparam logic [1:0] ERR_DOUBLE_POINT = 2'd2;
	localparam logic [1:0] ERR_ADJ_OP       = 2'd3;

	// Character codes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_POINT   = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_V = 8'h56;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_LOWER_V = 8'h76;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LCURLY  = 8'h7B;
	localparam logic [7:0] CH_RCURLY  = 8'h7D;

	// Input and result transactions
	typedef struct packed {
		logic [7:0] character;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [VALUE_W-1:0] value;
		logic [7:0]         symbol;
		logic [1:0]         error_code;
		logic               final_res;
	} result_t;

	// Token information that rides along the back pipeline
	typedef struct packed {
		logic                    num_v;
		logic [INTEGER_BITS-1:0] acc;
		logic                    tok_v;
		logic [2:0]              kind;
		logic [7:0]              symbol;
		logic [1:0]              code;
		logic                    last;
	} tag_t;

	// One queue entry from front to back
	typedef struct packed {
		tag_t             tag;
		logic [MANT_W-1:0] mant;
		logic [CNT_W-1:0]  cnt;
	} entry_t;

	// Divider stage contents
	typedef struct packed {
		tag_t              tag;
		logic [REM_W-1:0]  rem;
		logic [MANT_W-1:0] div;
		logic [QUO_W-1:0]  quo;
	} stage_t;

	// Ten to the power of a fraction digit count
	function automatic logic [MANT_W-1:0] pow10(input logic [CNT_W-1:0] n);
		logic [MANT_W-1:0] p;
		p = MANT_W'(1);
		for (int i = 0; i < MAX_FRACTION_DIGITS; i++) begin
			if (CNT_W'(i) < n) begin
				p = (p << 3) + (p << 1);
			end
		end
		return p;
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
			c == CH_LOWER_V || c == CH_UNDER || c == CH_CARET;
	endfunction

	function automatic logic is_bracket(input logic [7:0] c);
		return c == CH_LPAREN || c == CH_RPAREN || c == CH_LSQUARE ||
			c == CH_RSQUARE || c == CH_LCURLY || c == CH_RCURLY;
	endfunction

endpackage
`default_nettype wire

>>> src/ael_front.sv
// Front end: classifies characters, builds raw numbers and issues queue entries.
`timescale 1ns / 1ps
`default_nettype none
module ael_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire ael_pkg::item_t  item,
	output logic                 entry_push,
	output ael_pkg::entry_t      entry
);

	localparam int IB = ael_pkg::INTEGER_BITS;
	localparam int MW = ael_pkg::MANT_W;
	localparam int CW = ael_pkg::CNT_W;

	logic [IB-1:0] acc_q, acc_n;
	logic [MW-1:0] mant_q, mant_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          in_num_q, in_num_n;
	logic          point_q, point_n;
	logic          prev_op_q, prev_op_n;
	logic          err_q, err_n;

	logic [7:0]    c;
	logic          last;
	logic          is_digit;
	logic [3:0]    digit;
	logic [IB-1:0] acc_base, acc_dig;
	logic [MW-1:0] mant_base, mant_dig;
	logic [CW-1:0] cnt_base;
	logic          point_base;
	logic          cnt_full;
	logic [IB+3:0] acc_x10;
	logic [MW+3:0] mant_x10;

	logic          num_v, tok_v;
	logic [2:0]    kind;
	logic [7:0]    sym;
	logic [1:0]    code;
	logic [IB-1:0] flush_acc;
	logic [MW-1:0] flush_mant;
	logic [CW-1:0] flush_cnt;

	assign c        = item.character;
	assign last     = item.end_of_text;
	assign is_digit = (c >= ael_pkg::CH_ZERO) && (c <= ael_pkg::CH_NINE);
	assign digit    = c[3:0];

	// A new number starts from zero
	assign acc_base   = in_num_q ? acc_q : '0;
	assign mant_base  = in_num_q ? mant_q : '0;
	assign cnt_base   = in_num_q ? cnt_q : '0;
	assign point_base = in_num_q & point_q;
	assign cnt_full   = cnt_base >= CW'(ael_pkg::MAX_FRACTION_DIGITS);

	// Append one decimal digit, saturating the integer part
	assign acc_x10  = ((IB+4)'(acc_base) << 3) + ((IB+4)'(acc_base) << 1) + (IB+4)'(digit);
	assign acc_dig  = (|acc_x10[IB+3:IB]) ? '1 : acc_x10[IB-1:0];
	assign mant_x10 = ((MW+4)'(mant_base) << 3) + ((MW+4)'(mant_base) << 1) + (MW+4)'(digit);
	assign mant_dig = mant_x10[MW-1:0];

	// Classify the character and work out the tokens it produces
	always_comb begin
		acc_n      = acc_q;
		mant_n     = mant_q;
		cnt_n      = cnt_q;
		in_num_n   = in_num_q;
		point_n    = point_q;
		prev_op_n  = prev_op_q;
		err_n      = err_q;
		num_v      = 1'b0;
		tok_v      = 1'b0;
		kind       = ael_pkg::KIND_NUM;
		sym        = '0;
		code       = ael_pkg::ERR_UNKNOWN;
		flush_acc  = acc_q;
		flush_mant = mant_q;
		flush_cnt  = cnt_q;

		if (err_q) begin
			if (last) begin
				tok_v = 1'b1;
				kind  = ael_pkg::KIND_END;
			end
		end else if (is_digit) begin
			in_num_n = 1'b1;
			point_n  = point_base;
			if (!in_num_q) begin
				prev_op_n = 1'b0;
			end
			acc_n  = point_base ? acc_base : acc_dig;
			mant_n = (point_base && !cnt_full) ? mant_dig : mant_base;
			cnt_n  = (point_base && !cnt_full) ? cnt_base + CW'(1) : cnt_base;
			flush_acc  = acc_n;
			flush_mant = mant_n;
			flush_cnt  = cnt_n;
			num_v      = last;
		end else if (c == ael_pkg::CH_POINT && in_num_q) begin
			if (point_q) begin
				// Double point drops the pending number
				tok_v    = 1'b1;
				kind     = ael_pkg::KIND_ERR;
				sym      = c;
				code     = ael_pkg::ERR_DOUBLE_POINT;
				err_n    = 1'b1;
				in_num_n = 1'b0;
				point_n  = 1'b0;
			end else begin
				point_n = 1'b1;
				num_v   = last;
			end
		end else begin
			// Flush the pending number, then handle the character
			num_v    = in_num_q;
			in_num_n = 1'b0;
			point_n  = 1'b0;
			if (c == ael_pkg::CH_SPACE) begin
				prev_op_n = 1'b0;
			end else if (c == ael_pkg::CH_UPPER_V) begin
				tok_v = 1'b1;
				kind  = ael_pkg::KIND_ERR;
				sym   = c;
				code  = ael_pkg::ERR_UPPER_V;
				err_n = 1'b1;
			end else if (ael_pkg::is_operator(c)) begin
				tok_v = 1'b1;
				sym   = c;
				if (prev_op_q) begin
					kind  = ael_pkg::KIND_ERR;
					code  = ael_pkg::ERR_ADJ_OP;
					err_n = 1'b1;
				end else begin
					kind      = ael_pkg::KIND_OP;
					prev_op_n = 1'b1;
				end
			end else if (ael_pkg::is_bracket(c)) begin
				tok_v     = 1'b1;
				kind      = ael_pkg::KIND_BR;
				sym       = c;
				prev_op_n = 1'b0;
			end else begin
				tok_v = 1'b1;
				kind  = ael_pkg::KIND_ERR;
				sym   = c;
				code  = ael_pkg::ERR_UNKNOWN;
				err_n = 1'b1;
			end
			if (last && !num_v && !tok_v) begin
				tok_v = 1'b1;
				kind  = ael_pkg::KIND_END;
			end
		end

		// The last character returns everything to the reset state
		if (last) begin
			acc_n     = '0;
			mant_n    = '0;
			cnt_n     = '0;
			in_num_n  = 1'b0;
			point_n   = 1'b0;
			prev_op_n = 1'b0;
			err_n     = 1'b0;
		end
	end

	// Build the queue entry
	assign entry_push       = accept && (num_v || tok_v);
	assign entry.tag.num_v  = num_v;
	assign entry.tag.acc    = flush_acc;
	assign entry.tag.tok_v  = tok_v;
	assign entry.tag.kind   = kind;
	assign entry.tag.symbol = sym;
	assign entry.tag.code   = code;
	assign entry.tag.last   = last;
	assign entry.mant       = flush_mant;
	assign entry.cnt        = flush_cnt;

	// Advance the lexer state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			mant_q    <= '0;
			cnt_q     <= '0;
			in_num_q  <= 1'b0;
			point_q   <= 1'b0;
			prev_op_q <= 1'b0;
			err_q     <= 1'b0;
		end else if (accept) begin
			acc_q     <= acc_n;
			mant_q    <= mant_n;
			cnt_q     <= cnt_n;
			in_num_q  <= in_num_n;
			point_q   <= point_n;
			prev_op_q <= prev_op_n;
			err_q     <= err_n;
		end
	end

endmodule
`default_nettype wire

>>> src/ael_mid_fifo.sv
// Short entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none
module ael_mid_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire ael_pkg::entry_t  wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output ael_pkg::entry_t       rd_data,
	output logic                  empty
);

	localparam int PW = ael_pkg::MID_PTR_W;
	localparam int NW = ael_pkg::MID_CNT_W;

	ael_pkg::entry_t mem_q [ael_pkg::MID_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]   cnt_q;
	logic            do_wr, do_rd;

	assign full    = cnt_q == NW'(ael_pkg::MID_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(do_wr) - NW'(do_rd);
		end
	end

endmodule
`default_nettype wire

>>> src/ael_back.sv
// Back end: fraction divider pipeline, value saturation and result queue.
`timescale 1ns / 1ps
`default_nettype none
module ael_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             entry_valid,
	input  wire ael_pkg::entry_t  entry,
	output logic                  entry_pop,
	output logic                  empty,
	input  wire logic             pop,
	output ael_pkg::result_t      result
);

	localparam int QW  = ael_pkg::QUO_W;
	localparam int RW  = ael_pkg::REM_W;
	localparam int SW  = ael_pkg::SUM_W;
	localparam int FB  = ael_pkg::FRACTION_BITS;
	localparam int PW  = ael_pkg::OUT_PTR_W;
	localparam int NW  = ael_pkg::OUT_CNT_W;

	logic             valid_s [QW+1];
	ael_pkg::stage_t  data_s  [QW+1];
	ael_pkg::stage_t  step_d  [QW+1];
	ael_pkg::stage_t  load;
	logic             adv;

	ael_pkg::stage_t  tail;
	logic             tail_v;
	logic [SW-1:0]    sum;
	logic [SW-2:0]    total;
	ael_pkg::result_t res_num, res_tok, res_first;
	logic             two_wr;

	ael_pkg::result_t out_q [ael_pkg::OUT_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_wr, do_rd;
	logic [NW-1:0]    n_wr;

	// Prepare the dividend and divisor: rounded mantissa * 2^F / 10^count
	always_comb begin
		load.tag = entry.tag;
		load.div = ael_pkg::pow10(entry.cnt);
		load.rem = (RW'(entry.mant) << FB) + RW'(load.div >> 1);
		load.quo = '0;
	end

	// Stall the whole pipeline when the tail stage holds an entry and the result queue lacks room for two
	assign tail    = data_s[QW];
	assign tail_v  = valid_s[QW];
	assign adv     = !tail_v || (cnt_q <= NW'(ael_pkg::OUT_DEPTH - 2));
	assign entry_pop = adv && entry_valid;

	// Stage 0 takes the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s[0] <= load;
		end
	end

	assign step_d[0] = data_s[0];

	// One quotient bit per stage, most significant first
	for (genvar k = 1; k <= QW; k++) begin : g_div
		localparam int B = QW - k;
		logic [RW-1:0] shifted;

		assign shifted = RW'(data_s[k-1].div) << B;

		always_comb begin
			step_d[k] = data_s[k-1];
			if (data_s[k-1].rem >= shifted) begin
				step_d[k].rem    = data_s[k-1].rem - shifted;
				step_d[k].quo[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				data_s[k] <= step_d[k];
			end
		end
	end

	// Join integer and fraction, saturating at the top of the format
	assign sum   = (SW'(tail.tag.acc) << FB) + SW'(tail.quo);
	assign total = sum[SW-1] ? '1 : sum[SW-2:0];

	always_comb begin
		res_num.kind       = ael_pkg::KIND_NUM;
		res_num.value      = ael_pkg::VALUE_W'(total);
		res_num.symbol     = '0;
		res_num.error_code = ael_pkg::ERR_UNKNOWN;
		res_num.final_res  = tail.tag.last && !tail.tag.tok_v;

		res_tok.kind       = tail.tag.kind;
		res_tok.value      = '0;
		res_tok.symbol     = tail.tag.symbol;
		res_tok.error_code = tail.tag.code;
		res_tok.final_res  = tail.tag.last;

		res_first = tail.tag.num_v ? res_num : res_tok;
	end

	// Result queue takes up to two transactions per cycle
	assign do_wr  = adv && tail_v;
	assign two_wr = tail.tag.num_v && tail.tag.tok_v;
	assign n_wr   = do_wr ? (two_wr ? NW'(2) : NW'(1)) : '0;
	assign empty  = cnt_q == '0;
	assign do_rd  = pop && !empty;
	assign result = out_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			out_q[wr_ptr_q] <= res_first;
			if (two_wr) begin
				out_q[wr_ptr_q + PW'(1)] <= res_tok;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_wr);
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + n_wr - NW'(do_rd);
		end
	end

endmodule
`default_nettype wire

>>> src/arithmetic_expression_lexer.sv
// Top level of the arithmetic expression lexer.
//
// Input queue side: a character transaction is taken when push is high and full is low;
// end_of_text marks the last character of an expression. One character a cycle is taken
// while the internal entry queue has room.
// Result queue side: while empty is low the oldest token sits on result; it leaves when
// pop is high. A character yields zero, one or two tokens; the last one carries final_res.
// Path: a character's tokens pass the entry queue, load stage 0, the fraction divider
// that resolves one quotient bit per stage and the result queue. Throughput is one entry
// a cycle while the result queue has room for two tokens; a character that yields two
// tokens fills two slots of the four-deep result queue.
// When pop stays low the result queue fills, the divider pipeline holds, the entry queue
// fills and full rises; nothing is dropped.
// Reset (arst_n low) empties both queues and the pipeline and returns the lexer to the
// start of an expression with no error pending.
`timescale 1ns / 1ps
`default_nettype none
module arithmetic_expression_lexer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire ael_pkg::item_t    item,
	output logic                   empty,
	input  wire logic              pop,
	output ael_pkg::result_t       result
);

	logic            accept;
	logic            entry_push;
	ael_pkg::entry_t front_entry;
	ael_pkg::entry_t head_entry;
	logic            mid_empty;
	logic            entry_pop;

	assign accept = push && !full;

	// Character classification and number building
	ael_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.entry_push (entry_push),
		.entry      (front_entry)
	);

	// Decoupling queue
	ael_mid_fifo u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (entry_push),
		.wr_data (front_entry),
		.full    (full),
		.rd_en   (entry_pop),
		.rd_data (head_entry),
		.empty   (mid_empty)
	);

	// Value conversion and result delivery
	ael_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (!mid_empty),
		.entry       (head_entry),
		.entry_pop   (entry_pop),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule
`default_nettype wire

>>> src/ael_checker.sv
// Port-level checker for the lexer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "arithmetic_expression_lexer_assert.svh"
module ael_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             push,
	input wire logic             full,
	input wire ael_pkg::item_t   item,
	input wire logic             empty,
	input wire logic             pop,
	input wire ael_pkg::result_t result
);

	// Hold a waiting result until it is taken
	`AEL_ASSERT_NEXT(a_out_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))

	// Full only rises after an accepted character transaction
	`AEL_ASSERT_NOW(a_full_rise, clk, arst_n, $rose(full), $past(push) && !$past(full))

	// An end marker always closes the expression
	`AEL_ASSERT_NOW(a_end_final, clk, arst_n, !empty && result.kind == ael_pkg::KIND_END, result.final_res)

	// Only number tokens carry a value
	`AEL_ASSERT_NOW(a_value_num, clk, arst_n, !empty && result.kind != ael_pkg::KIND_NUM, result.value == '0)

endmodule

bind arithmetic_expression_lexer ael_checker u_ael_checker (.*);
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the arithmetic expression lexer.
`timescale 1ns / 1ps
module testbench;
	import ael_pkg::*;

	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 100;
	localparam int SETTLE_CYCLES = 50;
	localparam int PHASE_ITEMS   = 510;

	localparam logic [VALUE_W-1:0] NO_VALUE  = '0;
	localparam logic [7:0]         NO_SYMBOL = '0;
	localparam logic [1:0]         NO_CODE   = '0;
	localparam result_t            NO_TOKEN  = '0;

	typedef enum logic [1:0] {PREV_NONE, PREV_NUMBER, PREV_OPERATOR, PREV_BRACKET} prev_kind_t;

	// One directed row: the character, whether its token is typed in, and that token
	typedef struct packed {
		item_t   stim;
		logic    pinned;
		result_t want;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    pop = 1'b0;
	item_t   item = '0;
	logic    full;
	logic    empty;
	result_t result;

	// Lexer state mirrored by the predictor
	logic [INTEGER_BITS-1:0] int_part;
	logic [31:0]             frac_digits;
	int                      frac_count;
	logic                    in_number;
	logic                    have_point;
	logic                    halted;
	prev_kind_t              last_kind;

	result_t    expected_tokens[$];
	result_t    due_token;
	logic [7:0] line_buf[$];
	int         mismatches = 0;
	int         tokens_seen = 0;
	int         quiet_cycles = 0;
	int         send_idle_pct = 0;
	int         drain_idle_pct = 0;
	int         send_pcts[3] = '{11, 54, 0};
	int         drain_pcts[3] = '{54, 11, 0};

	logic [7:0] operator_chars[7] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LOWER_V,
		CH_UNDER, CH_CARET};
	logic [7:0] bracket_chars[6] = '{CH_LPAREN, CH_RPAREN, CH_LSQUARE, CH_RSQUARE,
		CH_LCURLY, CH_RCURLY};

	// Directed rows: operators, brackets, errors, extremes of the character and the end flag
	row_t script[27] = '{
		{CH_SLASH, 1'b0, 1'b1, KIND_OP, NO_VALUE, CH_SLASH, NO_CODE, 1'b0},
		{CH_PLUS, 1'b0, 1'b1, KIND_ERR, NO_VALUE, CH_PLUS, ERR_ADJ_OP, 1'b0},
		{CH_SPACE, 1'b1, 1'b1, KIND_END, NO_VALUE, NO_SYMBOL, NO_CODE, 1'b1},
		{8'hFF, 1'b0, 1'b1, KIND_ERR, NO_VALUE, 8'hFF, ERR_UNKNOWN, 1'b0},
		{8'h00, 1'b1, 1'b1, KIND_END, NO_VALUE, NO_SYMBOL, NO_CODE, 1'b1},
		{CH_LPAREN, 1'b0, 1'b1, KIND_BR, NO_VALUE, CH_LPAREN, NO_CODE, 1'b0},
		{CH_ZERO + 8'd1, 1'b0, 1'b0, NO_TOKEN},
		{CH_POINT, 1'b0, 1'b0, NO_TOKEN},
		{CH_ZERO + 8'd5, 1'b0, 1'b0, NO_TOKEN},
		{CH_POINT, 1'b0, 1'b1, KIND_ERR, NO_VALUE, CH_POINT, ERR_DOUBLE_POINT, 1'b0},
		{CH_UPPER_V, 1'b1, 1'b1, KIND_END, NO_VALUE, NO_SYMBOL, NO_CODE, 1'b1},
		{CH_ZERO + 8'd7, 1'b0, 1'b0, NO_TOKEN},
		{CH_UPPER_V, 1'b0, 1'b0, NO_TOKEN},
		{CH_PLUS, 1'b1, 1'b1, KIND_END, NO_VALUE, NO_SYMBOL, NO_CODE, 1'b1},
		{CH_LOWER_V, 1'b0, 1'b1, KIND_OP, NO_VALUE, CH_LOWER_V, NO_CODE, 1'b0},
		{CH_LSQUARE, 1'b0, 1'b1, KIND_BR, NO_VALUE, CH_LSQUARE, NO_CODE, 1'b0},
		{CH_ZERO + 8'd3, 1'b0, 1'b0, NO_TOKEN},
		{CH_POINT, 1'b0, 1'b0, NO_TOKEN},
		{CH_ZERO + 8'd5, 1'b1, 1'b1, KIND_NUM, 48'h3_8000, NO_SYMBOL, NO_CODE, 1'b1},
		{CH_POINT, 1'b0, 1'b1, KIND_ERR, NO_VALUE, CH_POINT, ERR_UNKNOWN, 1'b0},
		{CH_SPACE, 1'b1, 1'b1, KIND_END, NO_VALUE, NO_SYMBOL, NO_CODE, 1'b1},
		{CH_MINUS, 1'b0, 1'b1, KIND_OP, NO_VALUE, CH_MINUS, NO_CODE, 1'b0},
		{CH_SPACE, 1'b0, 1'b0, NO_TOKEN},
		{CH_STAR, 1'b0, 1'b1, KIND_OP, NO_VALUE, CH_STAR, NO_CODE, 1'b0},
		{CH_RCURLY, 1'b0, 1'b1, KIND_BR, NO_VALUE, CH_RCURLY, NO_CODE, 1'b0},
		{CH_UNDER, 1'b0, 1'b1, KIND_OP, NO_VALUE, CH_UNDER, NO_CODE, 1'b0},
		{CH_CARET, 1'b1, 1'b1, KIND_ERR, NO_VALUE, CH_CARET, ERR_ADJ_OP, 1'b1}
	};

	arithmetic_expression_lexer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clear the pending number
	function automatic void drop_number();
		int_part = '0;
		frac_digits = '0;
		frac_count = 0;
		in_number = 1'b0;
		have_point = 1'b0;
	endfunction

	// Return to the start of an expression
	function automatic void restart_lexer();
		drop_number();
		last_kind = PREV_NONE;
		halted = 1'b0;
	endfunction

	// Queue an error token and ignore input until the end of the expression
	function automatic void trap(input logic [7:0] c, input logic [1:0] code);
		expected_tokens.push_back({KIND_ERR, NO_VALUE, c, code, 1'b0});
		drop_number();
		halted = 1'b1;
	endfunction

	// Turn a pending number into a saturated fixed-point token
	function automatic void flush_pending();
		logic [63:0] ceiling;
		logic [63:0] frac;
		logic [63:0] scale;
		logic [63:0] total;
		if (in_number) begin
			ceiling = (64'd1 << (INTEGER_BITS + FRACTION_BITS)) - 64'd1;
			frac = '0;
			if (frac_count != 0) begin
				scale = 64'd1;
				repeat (frac_count) scale = scale * 64'd10;
				frac = ((64'(frac_digits) << FRACTION_BITS) + scale / 64'd2) / scale;
			end
			if (64'(int_part) > ((ceiling - frac) >> FRACTION_BITS)) begin
				total = ceiling;
			end else begin
				total = (64'(int_part) << FRACTION_BITS) + frac;
			end
			expected_tokens.push_back({KIND_NUM, VALUE_W'(total), NO_SYMBOL, NO_CODE, 1'b0});
			drop_number();
		end
	endfunction

	// Predict the tokens of one accepted character and queue them
	function automatic void tokenize_char(input item_t it);
		logic [7:0] c;
		logic [7:0] digit;
		int         queued_at_entry;
		result_t    tail;
		c = it.character;
		queued_at_entry = expected_tokens.size();
		if (halted) begin
			if (it.end_of_text) begin
				expected_tokens.push_back({KIND_END, NO_VALUE, NO_SYMBOL, NO_CODE, 1'b1});
				restart_lexer();
			end
		end else begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				digit = c - CH_ZERO;
				if (!in_number) begin
					drop_number();
					in_number = 1'b1;
					last_kind = PREV_NUMBER;
				end
				// saturate the integer part; drop fraction digits past the limit
				if (!have_point) begin
					if (64'(int_part) > (((64'd1 << INTEGER_BITS) - 64'd1 - 64'(digit)) / 64'd10)) begin
						int_part = '1;
					end else begin
						int_part = int_part * 10 + digit;
					end
				end else if (frac_count < MAX_FRACTION_DIGITS) begin
					frac_digits = frac_digits * 10 + digit;
					frac_count++;
				end
			end else if (c == CH_POINT && in_number) begin
				if (have_point) begin
					trap(c, ERR_DOUBLE_POINT);
				end else begin
					have_point = 1'b1;
				end
			end else begin
				flush_pending();
				case (c)
					CH_SPACE: begin
						last_kind = PREV_NONE;
					end
					CH_UPPER_V: begin
						trap(c, ERR_UPPER_V);
					end
					CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LOWER_V, CH_UNDER, CH_CARET: begin
						if (last_kind == PREV_OPERATOR) begin
							trap(c, ERR_ADJ_OP);
						end else begin
							expected_tokens.push_back({KIND_OP, NO_VALUE, c, NO_CODE, 1'b0});
							last_kind = PREV_OPERATOR;
						end
					end
					CH_LPAREN, CH_RPAREN, CH_LSQUARE, CH_RSQUARE, CH_LCURLY, CH_RCURLY: begin
						expected_tokens.push_back({KIND_BR, NO_VALUE, c, NO_CODE, 1'b0});
						last_kind = PREV_BRACKET;
					end
					default: begin
						trap(c, ERR_UNKNOWN);
					end
				endcase
			end
			// flush on the last character and mark its final token
			if (it.end_of_text) begin
				flush_pending();
				if (expected_tokens.size() == queued_at_entry) begin
					expected_tokens.push_back({KIND_END, NO_VALUE, NO_SYMBOL, NO_CODE, 1'b1});
				end else begin
					tail = expected_tokens.pop_back();
					tail.final_res = 1'b1;
					expected_tokens.push_back(tail);
				end
				restart_lexer();
			end
		end
	endfunction

	// Build one expression: mostly well formed, some with a stray character
	function automatic void compose_line();
		int         pieces;
		int         len;
		logic       operand_next;
		logic [7:0] stray;
		line_buf.delete();
		pieces = $urandom_range(0, 14);
		operand_next = 1'b1;
		for (int p = 0; p < pieces; p++) begin
			if ($urandom_range(99) < 15) begin
				line_buf.push_back(CH_SPACE);
			end
			if (operand_next) begin
				if ($urandom_range(99) < 75) begin
					// mostly short numbers, some long enough to saturate
					len = ($urandom_range(99) < 12) ? $urandom_range(10, 14) : $urandom_range(1, 4);
					repeat (len) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
					if ($urandom_range(99) < 40) begin
						line_buf.push_back(CH_POINT);
						repeat ($urandom_range(0, 7)) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
					end
					operand_next = 1'b0;
				end else begin
					line_buf.push_back(bracket_chars[2 * $urandom_range(2)]);
				end
			end else begin
				if ($urandom_range(99) < 80) begin
					line_buf.push_back(operator_chars[$urandom_range(6)]);
					operand_next = 1'b1;
				end else begin
					line_buf.push_back(bracket_chars[2 * $urandom_range(2) + 1]);
				end
			end
		end
		if ($urandom_range(99) < 25) begin
			case ($urandom_range(3))
				0: stray = 8'($urandom_range(255));
				1: stray = CH_UPPER_V;
				2: stray = CH_POINT;
				default: stray = operator_chars[$urandom_range(6)];
			endcase
			line_buf.insert($urandom_range(0, line_buf.size()), stray);
		end
		if (line_buf.size() == 0) begin
			line_buf.push_back(CH_SPACE);
		end
	endfunction

	// Offer one character, idling at random, and return at the edge that takes it
	task automatic offer_char(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Report a bad token; only the first few are printed
	task automatic log_mismatch(input string why, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected kind %0d value %h symbol %h code %0d final %0b",
				$realtime, why, want.kind, want.value, want.symbol, want.error_code,
				want.final_res);
			$display("    got kind %0d value %h symbol %h code %0d final %0b",
				got.kind, got.value, got.symbol, got.error_code, got.final_res);
		end
	endtask

	// Check each result transaction against the oldest expected token
	always @(posedge clk) begin
		if (pop && !empty) begin
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				log_mismatch("unexpected token", NO_TOKEN, result);
			end else begin
				due_token = expected_tokens.pop_front();
				if (result.kind !== due_token.kind || result.value !== due_token.value ||
						result.symbol !== due_token.symbol ||
						result.error_code !== due_token.error_code ||
						result.final_res !== due_token.final_res) begin
					log_mismatch("token mismatch", due_token, result);
				end
			end
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[arithmetic_expression_lexer] ERROR");
			$finish;
		end
	end

	// Drain results; hold off once for a long stretch so the lexer backs up
	initial begin : drain
		logic held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && tokens_seen >= HOLD_AFTER) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= ($urandom_range(99) >= drain_idle_pct);
		end
	end

	initial begin : stimulus
		int sent;
		restart_lexer();
		send_idle_pct = send_pcts[0];
		drain_idle_pct = drain_pcts[0];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows; a typed token stands in for the predicted one
		for (int r = 0; r < $size(script); r++) begin
			offer_char(script[r].stim);
			tokenize_char(script[r].stim);
			if (script[r].pinned) begin
				void'(expected_tokens.pop_back());
				expected_tokens.push_back(script[r].want);
			end
		end

		// random expressions under each idling mix
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = send_pcts[ph];
			drain_idle_pct = drain_pcts[ph];
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				compose_line();
				foreach (line_buf[k]) begin
					offer_char({line_buf[k], k == line_buf.size() - 1});
					tokenize_char({line_buf[k], k == line_buf.size() - 1});
					sent++;
				end
			end
		end
		push <= 1'b0;

		// wait out the pipeline, then report
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[arithmetic_expression_lexer] OK");
		end else begin
			$display("[arithmetic_expression_lexer] ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/ael_pkg.sv
src/ael_front.sv
src/ael_mid_fifo.sv
src/ael_back.sv
src/arithmetic_expression_lexer.sv
src/ael_checker.sv
verif/testbench.sv
